// File: rtl/pft_pkg.sv
// shared types and constants for the polygon fan triangulator
package pft_pkg;

  // width of one vertex index
  localparam int unsigned VERTEX_W = 16;

  typedef logic [VERTEX_W-1:0] vertex_t;

endpackage

// File: rtl/polygon_fan_triangulator_top.sv
// polygon fan triangulator: corner index stream in, triangle fan out
//
// Takes a stream of polygon corners (vertex indices), each polygon closed by a
// terminator transaction, and breaks every polygon into a triangle fan. In
// counter-clockwise mode (cfg register = 1, the reset value) each corner from
// the third onward gives one triangle (first, previous, current) straight
// away, so corners flow at one transaction per cycle while the result side
// keeps up. In clockwise mode the corners sit in a corner memory of
// MAX_POLYGON_CORNERS entries, and the terminator drains the fan
// (last, v[i], v[i-1]) for i from n-2 down to 1. That drain reads the memory
// through its single registered read port: the read pipeline is primed first,
// then one triangle per cycle while the result side keeps up, and no new input
// transaction is taken until the drain is over. Corners past the memory size
// are dropped, and in clockwise mode every triangle of that polygon is flagged
// truncated. Polygons with fewer than three corners and repeated terminators
// give nothing. last_of_run marks the final triangle caused by one input
// transaction. The mode register is written through cfg_write_en and
// cfg_write_data and may only change while the block is idle. The result side
// has a single output register; a new input transaction is taken only when
// that register is empty or being emptied in the same cycle.
module polygon_fan_triangulator_top #(
  parameter int unsigned MAX_POLYGON_CORNERS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  // configuration
  input  logic             cfg_write_en,
  input  logic             cfg_write_data,
  // input channel
  input  logic             in_valid,
  output logic             in_ready,
  input  pft_pkg::vertex_t in_vertex_index,
  input  logic             in_is_terminator,
  // result channel
  output logic             out_valid,
  input  logic             out_ready,
  output pft_pkg::vertex_t out_corner_a,
  output pft_pkg::vertex_t out_corner_b,
  output pft_pkg::vertex_t out_corner_c,
  output logic             out_truncated,
  output logic             out_last_of_run
);

  // memory address width and corner count width (count reaches the depth)
  localparam int unsigned AW = $clog2(MAX_POLYGON_CORNERS);
  localparam int unsigned CW = $clog2(MAX_POLYGON_CORNERS + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(MAX_POLYGON_CORNERS);
  localparam logic [CW-1:0] CNT_MIN_FAN = CW'(3);
  localparam logic [CW-1:0] CNT_TWO = CW'(2);
  localparam logic [AW-1:0] IDX_ONE = AW'(1);
  localparam logic [AW-1:0] IDX_TWO = AW'(2);

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;  // taking corners and terminators
  localparam logic [1:0] ST_PRIME = 2'd1;  // first fan read returning
  localparam logic [1:0] ST_EMIT  = 2'd2;  // one clockwise triangle per cycle while the result slot is free

  logic [1:0]       state_r, state_nxt;
  logic             ccw_r;
  logic [CW-1:0]    count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  pft_pkg::vertex_t first_r, first_nxt;
  pft_pkg::vertex_t prev_r, prev_nxt;
  pft_pkg::vertex_t apex_r, apex_nxt;   // last corner actually stored
  logic [AW-1:0]    idx_r, idx_nxt;     // i of the next clockwise triangle
  pft_pkg::vertex_t hi_r, hi_nxt;       // corner v[i] of the next triangle
  logic             trunc_r, trunc_nxt;

  // corner memory, one write and one registered read port
  pft_pkg::vertex_t store_mem [MAX_POLYGON_CORNERS];
  pft_pkg::vertex_t rdata_r;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;

  // output register
  logic             out_valid_r;
  pft_pkg::vertex_t out_a_r, out_b_r, out_c_r;
  logic             out_trunc_r, out_last_r;
  logic             out_load;
  pft_pkg::vertex_t out_a_nxt, out_b_nxt, out_c_nxt;
  logic             out_trunc_nxt, out_last_nxt;

  logic             out_free;
  logic             in_accept;
  logic             corner_acc;
  logic             term_acc;
  logic             room;
  logic             start_fan;
  logic [CW-1:0]    count_m2;

  assign out_free   = !out_valid_r || out_ready;
  // interlock: nothing enters while the fan drains or the result slot is held
  assign in_ready   = (state_r == ST_IDLE) && out_free;
  assign in_accept  = in_valid && in_ready;
  assign corner_acc = in_accept && !in_is_terminator;
  assign term_acc   = in_accept && in_is_terminator;
  assign room       = (count_r != CNT_FULL);
  assign start_fan  = term_acc && !ccw_r && (count_r >= CNT_MIN_FAN);
  assign count_m2   = count_r - CNT_TWO;

  assign wr_en   = corner_acc && room;
  assign wr_addr = count_r[AW-1:0];

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ccw_r <= 1'b1;
    end else if (cfg_write_en) begin
      ccw_r <= cfg_write_data;
    end
  end

  // read address per state; the read data holds while a triangle is stalled
  always_comb begin
    rd_addr = count_m2[AW-1:0];
    rd_en   = 1'b1;
    case (state_r)
      ST_IDLE: begin
        rd_addr = count_m2[AW-1:0];           // v[n-2] for a starting fan
      end
      ST_PRIME: begin
        rd_addr = idx_r - IDX_ONE;            // v[i-1]
      end
      ST_EMIT: begin
        rd_addr = idx_r - IDX_TWO;            // v[i-2] for the triangle after
        rd_en   = out_free;
      end
      default: begin
        rd_addr = count_m2[AW-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= in_vertex_index;
    end
    if (rd_en) begin
      rdata_r <= store_mem[rd_addr];
    end
  end

  // control and fan tracking
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    first_nxt     = first_r;
    prev_nxt      = prev_r;
    apex_nxt      = apex_r;
    idx_nxt       = idx_r;
    hi_nxt        = hi_r;
    trunc_nxt     = trunc_r;
    out_load      = 1'b0;
    out_a_nxt     = out_a_r;
    out_b_nxt     = out_b_r;
    out_c_nxt     = out_c_r;
    out_trunc_nxt = out_trunc_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (corner_acc) begin
          if (count_r == '0) begin
            first_nxt = in_vertex_index;
          end
          if (room) begin
            count_nxt = count_r + CW'(1);
            apex_nxt  = in_vertex_index;
          end else begin
            ovf_nxt = 1'b1;
          end
          prev_nxt = in_vertex_index;
          // forward fan around the first corner
          if (ccw_r && (count_r >= CNT_TWO)) begin
            out_load      = 1'b1;
            out_a_nxt     = first_r;
            out_b_nxt     = prev_r;
            out_c_nxt     = in_vertex_index;
            out_trunc_nxt = 1'b0;
            out_last_nxt  = 1'b1;
          end
        end
        if (term_acc) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          if (start_fan) begin
            idx_nxt   = count_m2[AW-1:0];
            trunc_nxt = ovf_r;
            state_nxt = ST_PRIME;
          end
        end
      end
      ST_PRIME: begin
        hi_nxt    = rdata_r;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_a_nxt     = apex_r;
          out_b_nxt     = hi_r;
          out_c_nxt     = rdata_r;
          out_trunc_nxt = trunc_r;
          out_last_nxt  = (idx_r == IDX_ONE);
          hi_nxt        = rdata_r;
          idx_nxt       = idx_r - IDX_ONE;
          if (idx_r == IDX_ONE) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      first_r     <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovf_r    <= ovf_nxt;
      first_r  <= first_nxt;
      prev_r   <= prev_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    apex_r      <= apex_nxt;
    idx_r       <= idx_nxt;
    hi_r        <= hi_nxt;
    trunc_r     <= trunc_nxt;
    out_a_r     <= out_a_nxt;
    out_b_r     <= out_b_nxt;
    out_c_r     <= out_c_nxt;
    out_trunc_r <= out_trunc_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_corner_a    = out_a_r;
  assign out_corner_b    = out_b_r;
  assign out_corner_c    = out_c_r;
  assign out_truncated   = out_trunc_r;
  assign out_last_of_run = out_last_r;

endmodule

// File: rtl/pft_checker.sv
// port-level checker for the polygon fan triangulator, bound to the top level
module pft_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_is_terminator,
  input logic             out_valid,
  input logic             out_ready,
  input pft_pkg::vertex_t out_corner_a,
  input pft_pkg::vertex_t out_corner_b,
  input pft_pkg::vertex_t out_corner_c,
  input logic             out_truncated,
  input logic             out_last_of_run
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_corner_a) &&
    $stable(out_corner_b) && $stable(out_corner_c) &&
    $stable(out_truncated) && $stable(out_last_of_run))
    else $error("result changed while stalled");

  // the single result slot blocks new input while it is held
  a_slot_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result slot held");

  // a terminator never yields a triangle in the following cycle
  a_term_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_is_terminator |=> !out_valid)
    else $error("triangle straight after terminator");

  // a fan in progress keeps the input closed
  a_drain_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> !in_ready)
    else $error("input taken during fan drain");

  // truncated triangles only come from a drained fan, never alone
  a_trunc_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_truncated && out_ready && !out_last_of_run |=> out_valid)
    else $error("fan drain broke off");

endmodule

bind polygon_fan_triangulator_top pft_checker u_pft_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_is_terminator (in_is_terminator),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_corner_a     (out_corner_a),
  .out_corner_b     (out_corner_b),
  .out_corner_c     (out_corner_c),
  .out_truncated    (out_truncated),
  .out_last_of_run  (out_last_of_run)
);

// File: sim/tb_polygon_fan_triangulator_top.sv
// self-checking testbench for the polygon fan triangulator top level
`timescale 1ns / 1ps

module tb_polygon_fan_triangulator_top;

  // block configuration and run control
  localparam int unsigned CORNER_CAP    = 64;
  localparam int unsigned CLK_HALF      = 4;
  localparam int unsigned RESET_CYCLES  = 6;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned PHASE_ITEMS   = 5;
  localparam int unsigned NUM_PHASES    = 8;

  // winding mode register values
  localparam bit MODE_CW  = 1'b0;
  localparam bit MODE_CCW = 1'b1;

  // idle profiles: none, sender idle, receiver stalling, both
  localparam int unsigned SEND_IDLE[4]  = '{0, 65, 0, 35};
  localparam int unsigned RECV_STALL[4] = '{0, 0, 65, 35};

  // one oversized or full polygon per phase where non-zero
  localparam int unsigned BIG_POLY[NUM_PHASES] = '{0, 66, 0, 0, 64, 0, 0, 0};

  typedef struct {
    pft_pkg::vertex_t vertex;
    bit               term;
    bit               pause;
  } corner_item_t;

  typedef struct {
    pft_pkg::vertex_t a;
    pft_pkg::vertex_t b;
    pft_pkg::vertex_t c;
    bit               trunc;
    bit               last;
  } triangle_t;

  logic             clk              = 1'b0;
  logic             rst_n            = 1'b0;
  logic             cfg_write_en     = 1'b0;
  logic             cfg_write_data   = 1'b0;
  logic             in_valid         = 1'b0;
  logic             in_ready;
  pft_pkg::vertex_t in_vertex_index  = '0;
  logic             in_is_terminator = 1'b0;
  logic             out_valid;
  logic             out_ready        = 1'b0;
  pft_pkg::vertex_t out_corner_a;
  pft_pkg::vertex_t out_corner_b;
  pft_pkg::vertex_t out_corner_c;
  logic             out_truncated;
  logic             out_last_of_run;

  // stimulus queue, fed by the sequencer and drained by the driver
  corner_item_t pending_corners[$];
  // triangles the fan predictor says are still to come
  triangle_t    expected_tris[$];

  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned pushed_count       = 0;
  int unsigned accepted_count     = 0;
  int unsigned tris_checked       = 0;
  int unsigned trunc_checked      = 0;
  int unsigned error_count        = 0;
  int unsigned cycle_count        = 0;
  bit          in_taken           = 1'b0;
  bit          pause_next         = 1'b0;

  // predictor state, a shadow of the block's polygon tracking
  bit               ccw_mode = MODE_CCW;
  pft_pkg::vertex_t corner_mem[CORNER_CAP];
  int unsigned      corner_cnt = 0;
  pft_pkg::vertex_t fan_first  = '0;
  pft_pkg::vertex_t fan_prev   = '0;
  bit               corner_overflow = 1'b0;

  polygon_fan_triangulator_top #(
    .MAX_POLYGON_CORNERS(CORNER_CAP)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_vertex_index  (in_vertex_index),
    .in_is_terminator (in_is_terminator),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_corner_a     (out_corner_a),
    .out_corner_b     (out_corner_b),
    .out_corner_c     (out_corner_c),
    .out_truncated    (out_truncated),
    .out_last_of_run  (out_last_of_run)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // fan predictor: updates the shadow state for one accepted transaction and
  // queues the triangles it gives
  task automatic assemble_fan(input pft_pkg::vertex_t vtx, input bit term);
    triangle_t        tri_item;
    pft_pkg::vertex_t prev;
    pft_pkg::vertex_t apex;
    int unsigned      seen;
    int               i;
    if (!term) begin
      seen = corner_cnt;
      prev = fan_prev;
      if (seen == 0) fan_first = vtx;
      // a full memory drops the corner but the tracked fan still moves on
      if (seen < CORNER_CAP) begin
        corner_mem[seen] = vtx;
        corner_cnt = seen + 1;
      end else begin
        corner_overflow = 1'b1;
      end
      fan_prev = vtx;
      if (ccw_mode == MODE_CCW && seen >= 2) begin
        tri_item = '{a: fan_first, b: prev, c: vtx, trunc: 1'b0, last: 1'b1};
        expected_tris.push_back(tri_item);
      end
    end else begin
      // clockwise close: fan backwards around the last stored corner
      if (ccw_mode == MODE_CW && corner_cnt >= 3) begin
        apex = corner_mem[corner_cnt-1];
        for (i = corner_cnt - 2; i >= 1; i--) begin
          tri_item = '{a: apex, b: corner_mem[i], c: corner_mem[i-1],
                       trunc: corner_overflow, last: (i == 1)};
          expected_tris.push_back(tri_item);
        end
      end
      corner_cnt = 0;
      corner_overflow = 1'b0;
    end
  endtask

  // driver: presents pending transactions at the falling edge and holds them
  // until the handshake completes
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // still waiting for in_ready, payload held
    end else if (pending_corners.size() != 0 &&
                 !(pending_corners[0].pause && expected_tris.size() != 0) &&
                 $urandom_range(99) >= sender_idle_pct) begin
      in_vertex_index  <= pending_corners[0].vertex;
      in_is_terminator <= pending_corners[0].term;
      in_valid         <= 1'b1;
      void'(pending_corners.pop_front());
    end else begin
      // idle: scribble on the payload, the block must not look at it
      in_valid        <= 1'b0;
      in_vertex_index <= pft_pkg::vertex_t'($urandom);
    end
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // monitor: predicts on each accepted input transaction and checks each
  // accepted result transaction against the oldest prediction
  always @(posedge clk) begin
    triangle_t exp_tri;
    in_taken = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        accepted_count++;
        assemble_fan(in_vertex_index, in_is_terminator);
      end
      if (out_valid && out_ready) begin
        if (expected_tris.size() == 0) begin
          $error("unexpected triangle (%h, %h, %h) with no prediction waiting",
                 out_corner_a, out_corner_b, out_corner_c);
          error_count++;
        end else begin
          exp_tri = expected_tris.pop_front();
          tris_checked++;
          if (exp_tri.trunc) trunc_checked++;
          if (out_corner_a !== exp_tri.a) begin
            $error("corner_a: expected %h, got %h", exp_tri.a, out_corner_a);
            error_count++;
          end
          if (out_corner_b !== exp_tri.b) begin
            $error("corner_b: expected %h, got %h", exp_tri.b, out_corner_b);
            error_count++;
          end
          if (out_corner_c !== exp_tri.c) begin
            $error("corner_c: expected %h, got %h", exp_tri.c, out_corner_c);
            error_count++;
          end
          if (out_truncated !== exp_tri.trunc) begin
            $error("truncated: expected %b, got %b", exp_tri.trunc, out_truncated);
            error_count++;
          end
          if (out_last_of_run !== exp_tri.last) begin
            $error("last_of_run: expected %b, got %b", exp_tri.last, out_last_of_run);
            error_count++;
          end
        end
      end
    end
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d triangles outstanding",
               cycle_count, expected_tris.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // queue one transaction; a pause item waits for the result side to drain
  task automatic push_item(input pft_pkg::vertex_t vtx, input bit term);
    corner_item_t item;
    item = '{vertex: vtx, term: term, pause: pause_next || ($urandom_range(99) < 2)};
    pause_next = 1'b0;
    pending_corners.push_back(item);
    pushed_count++;
  endtask

  // a polygon of random corners closed by a terminator
  task automatic push_polygon(input int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++) push_item(pft_pkg::vertex_t'($urandom), 1'b0);
    push_item(pft_pkg::vertex_t'($urandom), 1'b1);
  endtask

  // wait for all transactions and results, then let the block go quiet
  task automatic settle();
    do @(negedge clk);
    while (accepted_count != pushed_count || expected_tris.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input bit mode);
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= mode;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
    ccw_mode = mode;
  endtask

  // sequencer: directed cases, then random phases over modes and idle profiles
  initial begin
    int unsigned ph;
    int unsigned start;
    int unsigned r;
    bit          mode;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // reset mode is counter-clockwise: triangle at the index extremes
    push_item(16'h0000, 1'b0);
    push_item(16'hFFFF, 1'b0);
    push_item(16'h1234, 1'b0);
    push_item(16'hFFFF, 1'b1);
    // quad with repeated corners, then a repeated terminator
    push_item(16'hFFFF, 1'b0);
    push_item(16'h0000, 1'b0);
    push_item(16'hFFFF, 1'b0);
    push_item(16'h0001, 1'b0);
    push_item(16'h0000, 1'b1);
    push_item(16'hABCD, 1'b1);
    // single corner polygon gives nothing
    push_item(16'h5555, 1'b0);
    push_item(16'h0000, 1'b1);
    // two corners forward, switch to clockwise mid polygon, close backwards
    push_item(16'h0010, 1'b0);
    push_item(16'h0020, 1'b0);
    settle();
    write_mode(MODE_CW);
    push_item(16'h0030, 1'b0);
    push_item(16'h0040, 1'b0);
    push_item(16'hFFFF, 1'b1);
    // clockwise triangle and a short polygon
    push_item(16'h0001, 1'b0);
    push_item(16'h0002, 1'b0);
    push_item(16'hFFFE, 1'b0);
    push_item(16'h0000, 1'b1);
    push_item(16'h7FFF, 1'b0);
    push_item(16'h8000, 1'b0);
    push_item(16'h0000, 1'b1);
    // buffered corners, switch back to forward: tracked fan still in place
    push_item(16'h0007, 1'b0);
    push_item(16'h0008, 1'b0);
    push_item(16'h0009, 1'b0);
    settle();
    write_mode(MODE_CCW);
    push_item(16'h000B, 1'b0);
    push_item(16'h0000, 1'b1);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      mode = (((ph % 2) == 0) ^ (ph >= 4)) ? MODE_CCW : MODE_CW;
      write_mode(mode);
      sender_idle_pct    = SEND_IDLE[ph % 4];
      receiver_stall_pct = RECV_STALL[ph % 4];
      // one full or overflowing polygon, then hold off until its fan is out
      if (BIG_POLY[ph] != 0) begin
        push_polygon(BIG_POLY[ph]);
        pause_next = 1'b1;
      end
      start = pushed_count;
      while (pushed_count - start < PHASE_ITEMS) begin
        r = $urandom_range(99);
        if (r < 10) begin
          push_item(pft_pkg::vertex_t'($urandom), 1'b1);
        end else if (r < 25) begin
          push_polygon($urandom_range(2, 1));
        end else if (r < 28) begin
          push_polygon($urandom_range(66, 60));
        end else begin
          push_polygon($urandom_range(9, 3));
        end
      end
    end

    settle();
    $display("ran %0d input transactions over both winding modes and four idle profiles",
             accepted_count);
    $display("checked %0d triangles, %0d of them flagged truncated",
             tris_checked, trunc_checked);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/pft_pkg.sv
rtl/polygon_fan_triangulator_top.sv
rtl/pft_checker.sv
sim/tb_polygon_fan_triangulator_top.sv
